@@ hw/rtl/gzhp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the gzip member header parser.
// No dependencies; used by gzhp_parser and gzip_header_parser_top.

package gzhp_pkg;

    localparam int DataWidth = 8;
    localparam int StatusWidth = 2;

    localparam logic [7:0] MAGIC0 = 8'h1f;
    localparam logic [7:0] MAGIC1 = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;
    localparam logic [7:0] FL_RESV = 8'hE0;

    localparam logic [StatusWidth-1:0] ST_OK = 2'd0;
    localparam logic [StatusWidth-1:0] ST_MAGIC = 2'd1;
    localparam logic [StatusWidth-1:0] ST_METHOD = 2'd2;
    localparam logic [StatusWidth-1:0] ST_TRUNC = 2'd3;

    // Packed so that is_payload sits in bit 0, header_end in bit 1, status in bits 3:2.
    typedef struct packed {
        logic [StatusWidth-1:0] status;
        logic                   header_end;
        logic                   is_payload;
    } gzhp_result_t;

endpackage

@@ hw/rtl/gzhp_parser.sv @@
`timescale 1ns / 1ps
// Header walk state and per-word classification of the gzip member header.
// Depends on gzhp_pkg.

module gzhp_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  logic [gzhp_pkg::DataWidth-1:0]    data_byte,
    input  logic                              last_in_chunk,
    output gzhp_pkg::gzhp_result_t            result
);

    localparam logic [3:0] PH_MAGIC0  = 4'd0;
    localparam logic [3:0] PH_MAGIC1  = 4'd1;
    localparam logic [3:0] PH_METHOD  = 4'd2;
    localparam logic [3:0] PH_FLAGS   = 4'd3;
    localparam logic [3:0] PH_FIXED   = 4'd4;
    localparam logic [3:0] PH_XLEN0   = 4'd5;
    localparam logic [3:0] PH_XLEN1   = 4'd6;
    localparam logic [3:0] PH_EXTRA   = 4'd7;
    localparam logic [3:0] PH_NAME    = 4'd8;
    localparam logic [3:0] PH_COMMENT = 4'd9;
    localparam logic [3:0] PH_HCRC0   = 4'd10;
    localparam logic [3:0] PH_HCRC1   = 4'd11;
    localparam logic [3:0] PH_PAYLOAD = 4'd12;

    localparam logic [1:0] LVL_FIXED = 2'd0;
    localparam logic [1:0] LVL_EXTRA = 2'd1;
    localparam logic [1:0] LVL_NAME  = 2'd2;
    localparam logic [1:0] LVL_COMMENT = 2'd3;

    logic [3:0]  phase_reg, phase_next, nxt;
    logic [3:0]  flags_reg, flags_next;
    logic [15:0] xrem_reg, xrem_next, xrem_full;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic [gzhp_pkg::StatusWidth-1:0] err_reg, err_next, err;
    logic        payload;
    logic        hend;

    // flags: bit0 hcrc, bit1 extra, bit2 name, bit3 comment
    function automatic logic [3:0] next_after(input logic [1:0] level, input logic [3:0] fl);
        logic [3:0] ph;
        begin
            if (level < LVL_EXTRA && fl[1]) begin
                ph = PH_XLEN0;
            end else if (level < LVL_NAME && fl[2]) begin
                ph = PH_NAME;
            end else if (level < LVL_COMMENT && fl[3]) begin
                ph = PH_COMMENT;
            end else if (fl[0]) begin
                ph = PH_HCRC0;
            end else begin
                ph = PH_PAYLOAD;
            end
            return ph;
        end
    endfunction

    always_comb begin
        flags_next = flags_reg;
        xrem_next  = xrem_reg;
        fcnt_next  = fcnt_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        err        = gzhp_pkg::ST_OK;
        payload    = 1'b0;
        hend       = 1'b0;
        nxt        = phase_reg;
        xrem_full  = {data_byte, xrem_reg[7:0]};

        if (err_reg != gzhp_pkg::ST_OK) begin
            err = err_reg;
        end else begin
            unique case (phase_reg)
                PH_MAGIC0: begin
                    if (data_byte != gzhp_pkg::MAGIC0) err = gzhp_pkg::ST_MAGIC;
                    else nxt = PH_MAGIC1;
                end
                PH_MAGIC1: begin
                    if (data_byte != gzhp_pkg::MAGIC1) err = gzhp_pkg::ST_MAGIC;
                    else nxt = PH_METHOD;
                end
                PH_METHOD: begin
                    if (data_byte != gzhp_pkg::METHOD_DEFLATE) err = gzhp_pkg::ST_METHOD;
                    else nxt = PH_FLAGS;
                end
                PH_FLAGS: begin
                    if ((data_byte & gzhp_pkg::FL_RESV) != 8'h00) begin
                        err = gzhp_pkg::ST_METHOD;
                    end else begin
                        flags_next = data_byte[4:1];
                        fcnt_next  = 3'd0;
                        nxt        = PH_FIXED;
                    end
                end
                PH_FIXED: begin
                    if (fcnt_reg >= 3'd5) begin
                        fcnt_next = 3'd0;
                        nxt       = next_after(LVL_FIXED, flags_reg);
                    end else begin
                        fcnt_next = fcnt_reg + 3'd1;
                    end
                end
                PH_XLEN0: begin
                    xrem_next = {8'h00, data_byte};
                    nxt       = PH_XLEN1;
                end
                PH_XLEN1: begin
                    xrem_next = xrem_full;
                    nxt = (xrem_full == 16'd0) ? next_after(LVL_EXTRA, flags_reg) : PH_EXTRA;
                end
                PH_EXTRA: begin
                    xrem_next = xrem_reg - 16'd1;
                    if (xrem_reg == 16'd1) nxt = next_after(LVL_EXTRA, flags_reg);
                end
                PH_NAME: begin
                    if (data_byte == 8'h00) nxt = next_after(LVL_NAME, flags_reg);
                end
                PH_COMMENT: begin
                    if (data_byte == 8'h00) nxt = next_after(LVL_COMMENT, flags_reg);
                end
                PH_HCRC0: nxt = PH_HCRC1;
                PH_HCRC1: nxt = PH_PAYLOAD;
                default: begin
                    payload = 1'b1;
                    nxt     = PH_PAYLOAD;
                end
            endcase

            if (!payload) begin
                if (err == gzhp_pkg::ST_OK && last_in_chunk) err = gzhp_pkg::ST_TRUNC;
                if (err == gzhp_pkg::ST_OK && nxt == PH_PAYLOAD) hend = 1'b1;
            end
            if (err != gzhp_pkg::ST_OK) begin
                err_next = err;
                hend     = 1'b0;
                payload  = 1'b0;
            end else begin
                phase_next = nxt;
            end
        end
    end

    assign result.status     = err;
    assign result.header_end = hend;
    assign result.is_payload = payload;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC0;
            flags_reg <= 4'd0;
            xrem_reg  <= 16'd0;
            fcnt_reg  <= 3'd0;
            err_reg   <= gzhp_pkg::ST_OK;
        end else if (step) begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            xrem_reg  <= xrem_next;
            fcnt_reg  <= fcnt_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ hw/rtl/gzip_header_parser_top.sv @@
`timescale 1ns / 1ps
// gzip member header parser: input word register, header walk, result register.
// An accepted word waits in the input register and moves to the result register once that is empty or being read.
// Throughput: one word per cycle while the m side does not stall.
// Reset (aresetn low, synchronous): both stages empty, parser back to first magic byte,
// stored error cleared. Depends on gzhp_pkg and gzhp_parser.

module gzip_header_parser_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_in_chunk
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_out
    output logic [3:0] m_tuser    // [0] is_payload, [1] header_end, [3:2] status
);

    logic                   in_valid_reg;
    logic [7:0]             in_data_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_data_reg;
    gzhp_pkg::gzhp_result_t out_user_reg;
    gzhp_pkg::gzhp_result_t result;
    logic                   advance;
    logic                   step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    gzhp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .data_byte     (in_data_reg),
        .last_in_chunk (in_last_reg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= in_data_reg;
            out_user_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_hend_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.header_end |-> result.status == gzhp_pkg::ST_OK && !result.is_payload)
        else $error("header end word carries an error or payload mark");

    a_payload_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.is_payload |-> result.status == gzhp_pkg::ST_OK)
        else $error("payload word carries an error");

    a_error_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.status != gzhp_pkg::ST_OK |=>
            !step || result.status == $past(result.status))
        else $error("stored error changed before reset");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("held input word lost");

endmodule
